// File: rtl/apa_pkg.sv
// Package for the phase-angle PWM timer: widths, codes, reset values and
// the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package apa_pkg;

    // compare timer width (tick count and compare value)
    localparam int CMP_W        = 16;

    // register and field widths
    localparam int HP_W         = 16;
    localparam int SCALE_W      = 15;
    localparam int BASIC_W      = 16;
    localparam int ONL_W        = 15;
    localparam int DUTY_W       = 15;
    localparam int RAW_W        = 16;
    localparam int ACT_W        = 2;
    localparam int OUT_TDATA_W  = 8;
    localparam int OUT_FIELDS   = 3;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 16;

    // on/off time product and serial divider
    localparam int PROD_W        = HP_W + SCALE_W;
    localparam int DIV_NUM_W     = 64;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_STEPS     = DIV_NUM_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    // near-zero / near-full duty thresholds
    localparam int NEAR_ZERO_MUL = 100;
    localparam int NEAR_FULL_MUL = 98;
    localparam int THR_W         = DUTY_W + 7;

    // extra ticks added after some compare matches
    localparam int MATCH_PAD     = 10;

    // register reset values
    localparam logic [HP_W-1:0]    HP_RESET    = 16'd10000;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 15'd1000;

    // input actions
    typedef logic [ACT_W-1:0] t_action;
    localparam t_action ACT_TICK       = 2'd0;
    localparam t_action ACT_ZERO_CROSS = 2'd1;
    localparam t_action ACT_SET_DUTY   = 2'd2;

    // configuration register indexes
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_HALF_PERIOD = 2'd0;
    localparam t_cfg_addr CFG_DUTY_SCALE  = 2'd1;
    localparam t_cfg_addr CFG_BASIC_LATCH = 2'd2;
    localparam t_cfg_addr CFG_ON_LATCH    = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic mul_load;
        logic div_start;
        logic cmp_load;
        logic out_load;
    } t_ctrl_cmd;

    // datapath/divider -> controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_ctrl_stat;

endpackage

`default_nettype wire

// File: rtl/apa_div.sv
// Serial restoring divider, four quotient bits per cycle.
// Uses apa_pkg for widths.
`default_nettype none

module apa_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [apa_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [apa_pkg::SCALE_W-1:0]   i_den,
    output logic                               o_done,
    output logic [apa_pkg::CMP_W-1:0]          o_quot
);

    logic [apa_pkg::DIV_NUM_W-1:0] r_acc, n_acc;
    logic [apa_pkg::SCALE_W-1:0]   r_rem, n_rem;
    logic [apa_pkg::SCALE_W-1:0]   r_den;
    logic [apa_pkg::SCALE_W:0]     w_trial;
    logic [apa_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    // four shift/compare/subtract steps; quotient bits shift into the numerator
    always_comb begin
        n_rem   = r_rem;
        n_acc   = r_acc;
        w_trial = '0;
        for (int k = 0; k < apa_pkg::DIV_STEP_BITS; k++) begin
            w_trial = {n_rem, n_acc[apa_pkg::DIV_NUM_W-1]};
            n_acc   = {n_acc[apa_pkg::DIV_NUM_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                w_trial  = w_trial - {1'b0, r_den};
                n_acc[0] = 1'b1;
            end
            n_rem = w_trial[apa_pkg::SCALE_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == apa_pkg::DIV_CNT_W'(apa_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // operands
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc[apa_pkg::CMP_W-1:0];

endmodule

`default_nettype wire

// File: rtl/apa_dpath.sv
// Datapath: configuration registers, duty, tick count, compare value, pin,
// on/off time product and the result register. Uses apa_pkg.
`default_nettype none

module apa_dpath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire apa_pkg::t_cfg_addr              i_cfg_addr,
    input  wire logic [apa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire apa_pkg::t_action                i_action,
    input  wire logic [apa_pkg::RAW_W-1:0]       i_duty_value,
    input  wire apa_pkg::t_ctrl_cmd              i_cmd,
    input  wire logic                            i_m_tready,
    input  wire logic [apa_pkg::CMP_W-1:0]       i_quot,
    output logic                                 o_need_div,
    output logic                                 o_out_free,
    output logic [apa_pkg::DIV_NUM_W-1:0]        o_div_num,
    output logic [apa_pkg::SCALE_W-1:0]          o_div_den,
    output logic                                 o_m_tvalid,
    output logic [apa_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);

    // configuration
    logic [apa_pkg::HP_W-1:0]    r_hp;
    logic [apa_pkg::SCALE_W-1:0] r_scale;
    logic [apa_pkg::BASIC_W-1:0] r_basic;
    logic [apa_pkg::ONL_W-1:0]   r_on_latch;

    // timer state
    logic [apa_pkg::DUTY_W-1:0] r_duty, n_duty;
    logic [apa_pkg::CMP_W-1:0]  r_tick, n_tick;
    logic [apa_pkg::CMP_W-1:0]  r_cmp;
    logic                       r_running, n_running;
    logic                       r_drive, n_drive;
    logic                       r_event, n_event;

    // pending compare reload
    logic                       r_sel_off, n_sel_off;
    logic [apa_pkg::CMP_W-1:0]  r_addend, n_addend;
    logic                       imm_load;
    logic [apa_pkg::CMP_W-1:0]  imm_cmp;
    logic                       n_need_div;

    // product for the divider
    logic [apa_pkg::PROD_W-1:0]  r_prod;
    logic                        r_neg;
    logic                        duty_gt;
    logic [apa_pkg::SCALE_W-1:0] mult_sel;

    // result register
    logic r_out_valid, r_out_pin, r_out_run, r_out_evt;

    logic                       mode_zero, mode_neg;
    logic [apa_pkg::CMP_W-1:0]  on_l2, basic2, pad, tick_inc, quot_x2;
    logic [apa_pkg::THR_W-1:0]  duty_x100, scale_x98;
    logic                       near_zero, near_full;

    assign mode_zero = (r_basic == '0);
    assign mode_neg  = r_basic[apa_pkg::BASIC_W-1];
    assign on_l2     = apa_pkg::CMP_W'({r_on_latch, 1'b0});
    assign basic2    = apa_pkg::CMP_W'($signed({r_basic, 1'b0}));
    assign pad       = apa_pkg::CMP_W'(apa_pkg::MATCH_PAD);
    assign tick_inc  = r_tick + 1'b1;

    assign duty_x100 = apa_pkg::THR_W'(r_duty) * apa_pkg::THR_W'(apa_pkg::NEAR_ZERO_MUL);
    assign scale_x98 = apa_pkg::THR_W'(r_scale) * apa_pkg::THR_W'(apa_pkg::NEAR_FULL_MUL);
    assign near_zero = duty_x100 < apa_pkg::THR_W'(r_scale);
    assign near_full = duty_x100 > scale_x98;

    // event decode: new state, and which compare reload (if any) follows
    always_comb begin
        n_duty     = r_duty;
        n_tick     = r_tick;
        n_running  = r_running;
        n_drive    = r_drive;
        n_event    = 1'b0;
        n_sel_off  = 1'b0;
        n_addend   = '0;
        n_need_div = 1'b0;
        imm_load   = 1'b0;
        imm_cmp    = '0;
        case (i_action)
            apa_pkg::ACT_TICK: begin
                if (r_running) begin
                    n_tick = tick_inc;
                    if (tick_inc == r_cmp) begin
                        n_event = 1'b1;
                        n_tick  = apa_pkg::CMP_W'(1);
                        if (mode_zero) begin
                            n_drive    = 1'b1;
                            n_need_div = 1'b1;
                            n_addend   = pad - on_l2;
                        end else if (mode_neg) begin
                            if (!r_drive) begin
                                n_drive    = 1'b1;
                                n_need_div = 1'b1;
                                n_addend   = '0 - on_l2;
                            end else begin
                                n_drive  = 1'b0;
                                imm_load = 1'b1;
                                imm_cmp  = pad - basic2;
                            end
                        end else begin
                            if (r_drive) begin
                                n_drive    = 1'b0;
                                n_need_div = 1'b1;
                                n_sel_off  = 1'b1;
                                n_addend   = on_l2;
                            end else begin
                                n_drive    = 1'b1;
                                n_need_div = 1'b1;
                                n_addend   = '0 - on_l2;
                            end
                        end
                    end
                end
            end
            apa_pkg::ACT_ZERO_CROSS: begin
                n_running = 1'b0;
                if (near_zero) begin
                    n_drive = 1'b0;
                end else if (near_full) begin
                    n_drive = 1'b1;
                end else begin
                    n_running = 1'b1;
                    n_tick    = apa_pkg::CMP_W'(1);
                    if (mode_zero) begin
                        n_drive    = 1'b0;
                        n_need_div = 1'b1;
                        n_sel_off  = 1'b1;
                        n_addend   = on_l2;
                    end else if (mode_neg) begin
                        n_drive    = 1'b0;
                        n_need_div = 1'b1;
                        n_sel_off  = 1'b1;
                        n_addend   = on_l2 + basic2;
                    end else begin
                        n_drive  = 1'b1;
                        imm_load = 1'b1;
                        imm_cmp  = basic2;
                    end
                end
            end
            apa_pkg::ACT_SET_DUTY: begin
                // clamp to [0, scale]
                if (i_duty_value[apa_pkg::RAW_W-1]) begin
                    n_duty = '0;
                end else if (i_duty_value[apa_pkg::DUTY_W-1:0] >= r_scale) begin
                    n_duty = r_scale;
                end else begin
                    n_duty = i_duty_value[apa_pkg::DUTY_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_need_div = n_need_div;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp       <= apa_pkg::HP_RESET;
            r_scale    <= apa_pkg::SCALE_RESET;
            r_basic    <= '0;
            r_on_latch <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                apa_pkg::CFG_HALF_PERIOD: r_hp       <= i_cfg_data;
                apa_pkg::CFG_DUTY_SCALE:  r_scale    <= i_cfg_data[apa_pkg::SCALE_W-1:0];
                apa_pkg::CFG_BASIC_LATCH: r_basic    <= i_cfg_data;
                apa_pkg::CFG_ON_LATCH:    r_on_latch <= i_cfg_data[apa_pkg::ONL_W-1:0];
                default: ;
            endcase
        end
    end

    // zero scale gives zero on/off times
    assign quot_x2 = (r_scale == '0) ? '0 : {i_quot[apa_pkg::CMP_W-2:0], 1'b0};

    // timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty    <= '0;
            r_tick    <= '0;
            r_cmp     <= '0;
            r_running <= 1'b0;
            r_drive   <= 1'b0;
            r_event   <= 1'b0;
        end else if (i_cmd.accept) begin
            r_duty    <= n_duty;
            r_tick    <= n_tick;
            r_running <= n_running;
            r_drive   <= n_drive;
            r_event   <= n_event;
            if (imm_load) begin
                r_cmp <= imm_cmp;
            end
        end else if (i_cmd.cmp_load) begin
            r_cmp <= quot_x2 + r_addend;
        end
    end

    // pending reload, held while the divider works
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sel_off <= n_sel_off;
            r_addend  <= n_addend;
        end
    end

    // on time: hp*duty; off time: hp*(scale-duty), negative when duty > scale
    assign duty_gt  = r_duty > r_scale;
    assign mult_sel = !r_sel_off ? r_duty : (duty_gt ? r_duty - r_scale : r_scale - r_duty);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_prod <= apa_pkg::PROD_W'(r_hp) * apa_pkg::PROD_W'(mult_sel);
            r_neg  <= r_sel_off && duty_gt;
        end
    end

    assign o_div_num = r_neg ? apa_pkg::DIV_NUM_W'(0) - apa_pkg::DIV_NUM_W'(r_prod)
                             : apa_pkg::DIV_NUM_W'(r_prod);
    assign o_div_den = r_scale;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pin <= r_drive;
            r_out_run <= r_running;
            r_out_evt <= r_event;
        end
    end

    assign o_out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(apa_pkg::OUT_TDATA_W - apa_pkg::OUT_FIELDS){1'b0}},
                         r_out_evt, r_out_run, r_out_pin};

endmodule

`default_nettype wire

// File: rtl/apa_ctrl.sv
// Controller: sequences accept, product, divide, compare reload and result.
// Uses apa_pkg command/status structs.
`default_nettype none

module apa_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    input  wire apa_pkg::t_ctrl_stat i_stat,
    output logic                     o_s_tready,
    output apa_pkg::t_ctrl_cmd       o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_WAIT,
        ST_LOAD,
        ST_OUT
    } t_state;

    t_state r_state;
    logic   r_ready;
    logic   accept;

    assign accept = i_s_tvalid && r_ready;

    // commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = accept;
        o_cmd.mul_load  = (r_state == ST_MUL);
        o_cmd.div_start = (r_state == ST_START);
        o_cmd.cmp_load  = (r_state == ST_LOAD);
        o_cmd.out_load  = (r_state == ST_OUT) && i_stat.out_free;
    end

    assign o_s_tready = r_ready;

    // state and ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_ready <= 1'b0;
                        r_state <= i_stat.need_div ? ST_MUL : ST_OUT;
                    end
                end
                ST_MUL:   r_state <= ST_START;
                ST_START: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (i_stat.div_done) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD:  r_state <= ST_OUT;
                ST_OUT: begin
                    if (i_stat.out_free) begin
                        r_ready <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/ac_phase_angle_pwm_top.sv
// Channel   Dir  Payload
// s_axis    in   tuser[1:0] action, tdata[15:0] duty_value
// m_axis    out  tdata[0] pin_level, [1] timer_running, [2] compare_event
// cfg       in   i_cfg_addr selects register, i_cfg_data, i_cfg_we
//
// One item at a time. An item that reloads the compare value from an on or
// off time passes through the serial divider (4 bits a cycle over a 64-bit
// numerator); any other item goes straight to the result register.
// Synchronous active-low reset; no clearing pass. A stalled m_axis holds the
// result and keeps the next item from completing.
// Top level of the phase-angle PWM timer; instantiates apa_ctrl, apa_dpath
// and apa_div, uses apa_pkg.
`default_nettype none

module ac_phase_angle_pwm_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [apa_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [apa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [apa_pkg::RAW_W-1:0]         s_axis_tdata,  // [15:0] duty_value
    input  wire logic [apa_pkg::ACT_W-1:0]         s_axis_tuser,  // [1:0] action
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [apa_pkg::OUT_TDATA_W-1:0]        m_axis_tdata   // [0] pin_level,
                                                                  // [1] timer_running,
                                                                  // [2] compare_event
);

    apa_pkg::t_ctrl_cmd                cmd;
    apa_pkg::t_ctrl_stat               stat;
    logic                              need_div;
    logic                              out_free;
    logic                              div_done;
    logic [apa_pkg::DIV_NUM_W-1:0]     div_num;
    logic [apa_pkg::SCALE_W-1:0]       div_den;
    logic [apa_pkg::CMP_W-1:0]         quot;

    // status bundle
    always_comb begin
        stat          = '0;
        stat.need_div = need_div;
        stat.div_done = div_done;
        stat.out_free = out_free;
    end

    apa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_stat     (stat),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd)
    );

    apa_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_action     (s_axis_tuser),
        .i_duty_value (s_axis_tdata),
        .i_cmd        (cmd),
        .i_m_tready   (m_axis_tready),
        .i_quot       (quot),
        .o_need_div   (need_div),
        .o_out_free   (out_free),
        .o_div_num    (div_num),
        .o_div_den    (div_den),
        .o_m_tvalid   (m_axis_tvalid),
        .o_m_tdata    (m_axis_tdata)
    );

    apa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

endmodule

`default_nettype wire

// File: rtl/apa_checker.sv
// Port-level checks for the phase-angle PWM timer, bound to the top level.
// Uses apa_pkg for widths.
`default_nettype none

module apa_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [apa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while previous one in work");

    // a compare match always leaves the timer running
    a_evt_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
        else $error("compare event with timer stopped");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[apa_pkg::OUT_TDATA_W-1:apa_pkg::OUT_FIELDS] == '0)
        else $error("result padding not zero");

endmodule

bind ac_phase_angle_pwm_top apa_checker u_apa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the phase-angle PWM timer top level.
// Drives mains events and register writes, and checks every result item
// against a cycle-free timer model held here. Depends on apa_pkg and the RTL.

module testbench;

    import apa_pkg::*;

    localparam int        SETTLE_CYCLES = 40;    // covers the divider path
    localparam int        QUIET_LIMIT   = 4000;  // cycles with no item moved
    localparam int        N_PHASES      = 10;
    localparam int        PHASE_EVENTS  = 107;   // each phase overruns by its last chunk
    localparam int        MAX_TICKS     = 150;
    localparam int        HOLD_AFTER    = 500;   // input items before the long stall
    localparam int        HOLD_CYCLES   = 300;
    localparam t_action   ACT_NONE      = 2'd3;  // undefined action, ignored

    // one mains event as offered on the input stream
    typedef struct packed {
        t_action     action;
        logic [15:0] duty;
    } t_mains_event;

    // drive state reported after each event
    typedef struct packed {
        logic pin;
        logic running;
        logic compare_hit;
    } t_drive_state;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [RAW_W-1:0]      s_axis_tdata  = '0;  // [15:0] duty_value
    logic [ACT_W-1:0]      s_axis_tuser  = '0;  // [1:0] action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;       // [0] pin_level, [1] timer_running,
                                                // [2] compare_event

    ac_phase_angle_pwm_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // timer model: registers and state
    logic [HP_W-1:0]    hp_cfg    = HP_RESET;
    logic [SCALE_W-1:0] scale_cfg = SCALE_RESET;
    logic [BASIC_W-1:0] basic_cfg = '0;
    logic [ONL_W-1:0]   onl_cfg   = '0;
    logic [15:0]        duty_lvl  = '0;
    logic [CMP_W-1:0]   tick_cnt  = '0;
    logic [CMP_W-1:0]   cmp_val   = '0;
    logic               timer_on  = 1'b0;
    logic               pin_lvl   = 1'b0;

    t_mains_event pending_events[$];
    t_drive_state expected_drive[$];
    t_mains_event next_ev;
    t_drive_state want, got;

    int  n_sent      = 0;   // items put on the input bus
    int  n_in        = 0;   // items accepted
    int  n_out       = 0;   // results accepted
    int  n_mismatch  = 0;
    int  tx_gap      = 0;
    int  rx_stall    = 0;
    int  hold_left   = 0;
    int  quiet       = 0;
    bit  hold_done   = 1'b0;
    bit  calm        = 1'b0;  // no idling on either side

    // on/off times in ticks, 64-bit wrapping as the timer computes them
    function automatic logic [63:0] on_ticks();
        logic [63:0] sc;
        sc = 64'(scale_cfg);
        if (sc == 0) return 64'd0;
        return (64'(hp_cfg) * 64'(duty_lvl)) / sc * 2;
    endfunction

    function automatic logic [63:0] off_ticks();
        logic [63:0] sc;
        sc = 64'(scale_cfg);
        if (sc == 0) return 64'd0;
        return (64'(hp_cfg) * (sc - 64'(duty_lvl))) / sc * 2;
    endfunction

    function automatic logic [63:0] basic_ticks();
        logic [63:0] b;
        b = {{48{basic_cfg[15]}}, basic_cfg};
        return b * 2;
    endfunction

    // advance the timer model by one event and give the expected drive state
    task automatic step_timer(input t_mains_event ev, output t_drive_state res);
        logic        hit;
        logic [63:0] onl2;
        logic [63:0] next;
        hit  = 1'b0;
        onl2 = 64'(onl_cfg) * 2;
        case (ev.action)
            ACT_TICK: begin
                if (timer_on) begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt == cmp_val) begin
                        hit = 1'b1;
                        // compare match: mode rules set the pin and reload
                        if (basic_cfg == 0) begin
                            pin_lvl = 1'b1;
                            next    = on_ticks() - onl2 + MATCH_PAD;
                        end else if (!basic_cfg[15]) begin
                            if (pin_lvl) begin
                                pin_lvl = 1'b0;
                                next    = off_ticks() + onl2;
                            end else begin
                                pin_lvl = 1'b1;
                                next    = on_ticks() - onl2;
                            end
                        end else begin
                            if (!pin_lvl) begin
                                pin_lvl = 1'b1;
                                next    = on_ticks() - onl2;
                            end else begin
                                pin_lvl = 1'b0;
                                next    = 64'd0 - basic_ticks() + MATCH_PAD;
                            end
                        end
                        cmp_val  = next[CMP_W-1:0];
                        tick_cnt = 1;
                    end
                end
            end
            ACT_ZERO_CROSS: begin
                timer_on = 1'b0;
                if (64'(duty_lvl) * NEAR_ZERO_MUL < 64'(scale_cfg)) begin
                    pin_lvl = 1'b0;
                end else if (64'(duty_lvl) * NEAR_ZERO_MUL >
                             64'(scale_cfg) * NEAR_FULL_MUL) begin
                    pin_lvl = 1'b1;
                end else begin
                    if (basic_cfg == 0) begin
                        pin_lvl = 1'b0;
                        next    = off_ticks() + onl2;
                    end else if (!basic_cfg[15]) begin
                        pin_lvl = 1'b1;
                        next    = basic_ticks();
                    end else begin
                        pin_lvl = 1'b0;
                        next    = off_ticks() + onl2 + basic_ticks();
                    end
                    cmp_val  = next[CMP_W-1:0];
                    timer_on = 1'b1;
                    tick_cnt = 1;
                end
            end
            ACT_SET_DUTY: begin
                if (ev.duty[15])
                    duty_lvl = '0;
                else if (scale_cfg == 0 || ev.duty >= scale_cfg)
                    duty_lvl = 16'(scale_cfg);
                else
                    duty_lvl = ev.duty;
            end
            default: ;
        endcase
        res.pin         = pin_lvl;
        res.running     = timer_on;
        res.compare_hit = hit;
    endtask

    task automatic log_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        n_mismatch++;
    endtask

    task automatic add_event(input t_action act, input logic [15:0] val);
        pending_events.push_back('{action: act, duty: val});
    endtask

    // register write; only called with nothing in flight
    task automatic write_reg(input t_cfg_addr idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_HALF_PERIOD: hp_cfg    = val;
            CFG_DUTY_SCALE:  scale_cfg = val[SCALE_W-1:0];
            CFG_BASIC_LATCH: basic_cfg = val;
            CFG_ON_LATCH:    onl_cfg   = val[ONL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0 || n_in != n_sent || expected_drive.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly whole half cycles (duty, zero crossing, ticks), some random noise
    task automatic fill_phase(input int budget);
        int n, k, ticks;
        n = 0;
        while (n < budget) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 3) != 0) begin
                    if ($urandom_range(0, 4) != 0)
                        add_event(ACT_SET_DUTY, 16'($urandom_range(0, int'(scale_cfg))));
                    else
                        add_event(ACT_SET_DUTY, 16'($urandom));
                    n++;
                end
                add_event(ACT_ZERO_CROSS, 16'($urandom));
                n++;
                ticks = $urandom_range(int'(hp_cfg), 2 * int'(hp_cfg) + 30);
                if (ticks > MAX_TICKS) ticks = MAX_TICKS;
                repeat (ticks) add_event(ACT_TICK, 16'($urandom));
                n += ticks;
            end else begin
                k = $urandom_range(1, 5);
                repeat (k) add_event(t_action'($urandom_range(0, 3)), 16'($urandom));
                n += k;
            end
        end
    endtask

    // input driver: one item on offer until taken, random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && n_in != n_sent) begin
            // item still waiting for acceptance
        end else if (tx_gap > 0) begin
            s_axis_tvalid <= 1'b0;
            tx_gap        <= tx_gap - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            tx_gap        <= $urandom_range(0, 14);
        end else if (pending_events.size() != 0) begin
            next_ev       = pending_events.pop_front();
            s_axis_tuser  <= next_ev.action;
            s_axis_tdata  <= next_ev.duty;
            s_axis_tvalid <= 1'b1;
            n_sent        <= n_sent + 1;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (!hold_done && n_in >= HOLD_AFTER) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_stall      <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: check results first, then predict for a newly accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_drive.size() == 0) begin
                    log_mismatch($sformatf("result %0d with nothing outstanding", n_out));
                end else begin
                    want = expected_drive.pop_front();
                    if (m_axis_tdata[0] !== want.pin)
                        log_mismatch($sformatf("result %0d pin_level %b, want %b",
                                               n_out, m_axis_tdata[0], want.pin));
                    if (m_axis_tdata[1] !== want.running)
                        log_mismatch($sformatf("result %0d timer_running %b, want %b",
                                               n_out, m_axis_tdata[1], want.running));
                    if (m_axis_tdata[2] !== want.compare_hit)
                        log_mismatch($sformatf("result %0d compare_event %b, want %b",
                                               n_out, m_axis_tdata[2], want.compare_hit));
                end
                n_out <= n_out + 1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                step_timer('{action: s_axis_tuser, duty: s_axis_tdata}, got);
                expected_drive.push_back(got);
                n_in <= n_in + 1;
            end
        end
    end

    // watchdog on cycles in which no item moves
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int hp, sc, bl, ol;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset settings (timer too slow to match here)
        add_event(ACT_TICK, 16'h0000);        // tick while stopped
        add_event(ACT_NONE, 16'hFFFF);        // undefined action
        add_event(ACT_SET_DUTY, 16'h8000);    // most negative duty clamps to 0
        add_event(ACT_ZERO_CROSS, 16'h0000);  // near zero: pin low
        add_event(ACT_SET_DUTY, 16'h7FFF);    // largest duty clamps to scale
        add_event(ACT_ZERO_CROSS, 16'hFFFF);  // near full: pin high
        add_event(ACT_TICK, 16'hFFFF);
        add_event(ACT_SET_DUTY, 16'hFFFF);    // -1
        add_event(ACT_SET_DUTY, 16'd999);     // just under scale
        add_event(ACT_ZERO_CROSS, 16'h0000);
        add_event(ACT_SET_DUTY, 16'd1000);    // equal to scale
        add_event(ACT_SET_DUTY, 16'd9);       // last near-zero value
        add_event(ACT_SET_DUTY, 16'd10);      // first mid value
        add_event(ACT_ZERO_CROSS, 16'h5555);  // starts the timer
        add_event(ACT_TICK, 16'hAAAA);
        add_event(ACT_SET_DUTY, 16'd500);     // duty write leaves the timer alone
        add_event(ACT_TICK, 16'h0000);
        add_event(ACT_NONE, 16'h7FFF);
        add_event(ACT_SET_DUTY, 16'd0);
        add_event(ACT_ZERO_CROSS, 16'h0000);  // stops the timer
        add_event(ACT_TICK, 16'h0000);
        wait_idle();

        // register settings change between phases while the timer may run
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                1: begin hp = 0;     sc = 50;    bl = 0;      ol = 0;     end
                2: begin hp = 65535; sc = 32767; bl = 32767;  ol = 32767; end
                3: begin hp = 40;    sc = 0;     bl = -32768; ol = 0;     end
                4: begin hp = 30;    sc = 1;     bl = 5;      ol = 1;     end
                default: begin
                    hp = $urandom_range(1, 60);
                    sc = $urandom_range(1, 150);
                    case ($urandom_range(0, 2))
                        0:       bl = 0;
                        1:       bl = $urandom_range(1, 25);
                        default: bl = -int'($urandom_range(1, 25));
                    endcase
                    ol = $urandom_range(0, 4);
                end
            endcase
            if (p == N_PHASES - 1) calm = 1'b1;
            write_reg(CFG_HALF_PERIOD, 16'(hp));
            write_reg(CFG_DUTY_SCALE, 16'(sc));
            write_reg(CFG_BASIC_LATCH, 16'(bl));
            write_reg(CFG_ON_LATCH, 16'(ol));
            fill_phase(PHASE_EVENTS);
            wait_idle();
        end

        if (expected_drive.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", expected_drive.size()));
        if (n_mismatch == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
